// ===== rtl/core/rsg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the render scale governor.
// No dependencies; every other file of the block imports this package.
package rsg_pkg;

	localparam int DIM_W       = 14;
	localparam int TIME_W      = 24;
	localparam int SUM_W       = 32;
	localparam int BUDGET_W    = 28;
	localparam int WIN_W       = 8;
	localparam int REC_W       = 4;
	localparam int MODE_W      = 2;
	localparam int OP_W        = 2;
	localparam int LVL_W       = 3;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_QUERY  = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_AUTO   = 2'd0,
		MODE_HIGH   = 2'd1,
		MODE_MEDIUM = 2'd2,
		MODE_LOW    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_QUALITY  = 3'd0,
		REG_BUDGET   = 3'd1,
		REG_SLOW     = 3'd2,
		REG_FAST     = 3'd3,
		REG_WINDOW   = 3'd4,
		REG_RECOVERY = 3'd5
	} reg_idx_t;

	localparam logic [BUDGET_W-1:0] BUDGET_RST   = 28'd1600000;
	localparam logic [TIME_W-1:0]   SLOW_RST     = 24'd16700;
	localparam logic [TIME_W-1:0]   FAST_RST     = 24'd6000;
	localparam logic [WIN_W-1:0]    WINDOW_RST   = 8'd30;
	localparam logic [REC_W-1:0]    RECOVERY_RST = 4'd3;

	typedef struct packed {
		op_t               op;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [TIME_W-1:0] elapsed_us;
	} item_t;

	typedef struct packed {
		mode_t               quality_mode;
		logic [BUDGET_W-1:0] pixel_budget;
		logic [TIME_W-1:0]   slow_threshold_us;
		logic [TIME_W-1:0]   fast_threshold_us;
		logic [WIN_W-1:0]    window_samples;
		logic [REC_W-1:0]    recovery_windows;
	} cfg_t;

endpackage

// ===== rtl/core/rsg_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file of the render scale governor, APB-style port.
// Depends on rsg_pkg.
module rsg_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rsg_pkg::ADDR_W-1:0]  paddr,
	input  logic [rsg_pkg::DATA_W-1:0]  pwdata,
	output logic [rsg_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output rsg_pkg::cfg_t               cfg,
	output logic                        mode_change
);
	import rsg_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg    = cfg_q;

	assign mode_change = wr_en && (idx == REG_QUALITY) &&
		(pwdata[MODE_W-1:0] != cfg_q.quality_mode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quality_mode      <= MODE_AUTO;
			cfg_q.pixel_budget      <= BUDGET_RST;
			cfg_q.slow_threshold_us <= SLOW_RST;
			cfg_q.fast_threshold_us <= FAST_RST;
			cfg_q.window_samples    <= WINDOW_RST;
			cfg_q.recovery_windows  <= RECOVERY_RST;
		end else if (wr_en) begin
			case (idx)
				REG_QUALITY:  cfg_q.quality_mode      <= mode_t'(pwdata[MODE_W-1:0]);
				REG_BUDGET:   cfg_q.pixel_budget      <= pwdata[BUDGET_W-1:0];
				REG_SLOW:     cfg_q.slow_threshold_us <= pwdata[TIME_W-1:0];
				REG_FAST:     cfg_q.fast_threshold_us <= pwdata[TIME_W-1:0];
				REG_WINDOW:   cfg_q.window_samples    <= pwdata[WIN_W-1:0];
				REG_RECOVERY: cfg_q.recovery_windows  <= pwdata[REC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_QUALITY:  prdata = DATA_W'(cfg_q.quality_mode);
			REG_BUDGET:   prdata = DATA_W'(cfg_q.pixel_budget);
			REG_SLOW:     prdata = DATA_W'(cfg_q.slow_threshold_us);
			REG_FAST:     prdata = DATA_W'(cfg_q.fast_threshold_us);
			REG_WINDOW:   prdata = DATA_W'(cfg_q.window_samples);
			REG_RECOVERY: prdata = DATA_W'(cfg_q.recovery_windows);
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/rsg_level.sv =====
`timescale 1ns / 1ps
// Base level pipeline: one lane per scale below MAX_SCALE divides the frame size
// and compares the scaled pixel count against the budget. Depends on rsg_pkg.
module rsg_level #(
	parameter int MAX_SCALE = 4
) (
	input  logic                          clk,
	input  logic                          en_s2,
	input  logic                          en_s3,
	input  rsg_pkg::item_t                item_s1,
	input  logic [rsg_pkg::BUDGET_W-1:0]  pixel_budget,
	output rsg_pkg::item_t                item_s3,
	output logic [rsg_pkg::LVL_W-1:0]     level_s3
);
	import rsg_pkg::*;

	localparam int SHIFT   = DIM_W + $clog2(MAX_SCALE);
	localparam int RECIP_W = SHIFT + 1;
	localparam int PROD_W  = DIM_W + RECIP_W;
	localparam logic [LVL_W-1:0] MAX_L = LVL_W'(MAX_SCALE);

	item_t                item_s2;
	logic [DIM_W-1:0]     qw_s2 [1:MAX_SCALE-1];
	logic [DIM_W-1:0]     qh_s2 [1:MAX_SCALE-1];
	logic [MAX_SCALE-1:1] fit_s3;

	// Each lane divides by its scale as a multiply by the rounded-up reciprocal.
	for (genvar g = 1; g < MAX_SCALE; g++) begin : g_lane
		localparam int S = g;
		localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + S - 1) / S);
		logic [PROD_W-1:0]       pw;
		logic [PROD_W-1:0]       ph;
		logic [2*DIM_W-1:0]      area;

		assign pw   = PROD_W'(item_s1.width) * PROD_W'(RECIP);
		assign ph   = PROD_W'(item_s1.height) * PROD_W'(RECIP);
		assign area = (2*DIM_W)'(qw_s2[g]) * (2*DIM_W)'(qh_s2[g]);

		always_ff @(posedge clk) begin
			if (en_s2) begin
				qw_s2[g] <= DIM_W'(pw >> SHIFT);
				qh_s2[g] <= DIM_W'(ph >> SHIFT);
			end
			if (en_s3) begin
				fit_s3[g] <= (area <= (2*DIM_W)'(pixel_budget));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			item_s2 <= item_s1;
		end
		if (en_s3) begin
			item_s3 <= item_s2;
		end
	end

	always_comb begin
		level_s3 = MAX_L;
		for (int i = MAX_SCALE - 1; i >= 1; i--) begin
			if (fit_s3[i]) begin
				level_s3 = LVL_W'(i);
			end
		end
	end

endmodule

// ===== rtl/core/rsg_state.sv =====
`timescale 1ns / 1ps
// Governor state and result register: applies one request per cycle, when
// enabled, to the held frame size, scales and window counters. Depends on rsg_pkg.
module rsg_state #(
	parameter int MAX_SCALE = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  rsg_pkg::item_t             item,
	input  logic [rsg_pkg::LVL_W-1:0]  level,
	input  rsg_pkg::cfg_t              cfg,
	input  logic                       mode_change,
	output logic [rsg_pkg::LVL_W-1:0]  scale,
	output logic [rsg_pkg::LVL_W-1:0]  floor_scale
);
	import rsg_pkg::*;

	localparam logic [LVL_W-1:0] MAX_L = LVL_W'(MAX_SCALE);
	localparam logic [LVL_W-1:0] ONE_L = LVL_W'(1);
	localparam logic [LVL_W-1:0] TWO_L = LVL_W'(2);
	localparam logic [LVL_W-1:0] TRI_L = LVL_W'(3);

	logic [DIM_W-1:0]  held_w_q, held_h_q, held_w_d, held_h_d;
	logic [LVL_W-1:0]  base_q, cur_q, base_d, cur_d;
	logic [WIN_W-1:0]  cnt_q, cnt_d, cnt_inc, win;
	logic [SUM_W-1:0]  sum_q, sum_d, sum_inc, slow_lim, fast_lim;
	logic [REC_W-1:0]  calm_q, calm_d, calm_inc;
	logic [LVL_W-1:0]  scale_q, floor_q;

	assign cnt_inc  = cnt_q + WIN_W'(1);
	assign sum_inc  = sum_q + SUM_W'(item.elapsed_us);
	assign calm_inc = calm_q + REC_W'(1);
	assign win      = (cfg.window_samples == '0) ? WIN_W'(1) : cfg.window_samples;
	assign slow_lim = SUM_W'(cfg.slow_threshold_us) * SUM_W'(cnt_inc);
	assign fast_lim = SUM_W'(cfg.fast_threshold_us) * SUM_W'(cnt_inc);

	always_comb begin
		held_w_d = held_w_q;
		held_h_d = held_h_q;
		base_d   = base_q;
		cur_d    = cur_q;
		cnt_d    = cnt_q;
		sum_d    = sum_q;
		calm_d   = calm_q;
		unique case (item.op)
			OP_QUERY: begin
				if (item.width != held_w_q || item.height != held_h_q) begin
					held_w_d = item.width;
					held_h_d = item.height;
					base_d   = level;
					cur_d    = level;
					cnt_d    = '0;
					sum_d    = '0;
					calm_d   = '0;
				end
				unique case (cfg.quality_mode)
					MODE_AUTO:   begin
					end
					MODE_HIGH:   cur_d = ONE_L;
					MODE_MEDIUM: cur_d = (base_d < TWO_L) ? TWO_L : base_d;
					MODE_LOW:    cur_d = (base_d < TRI_L) ? TRI_L : base_d;
				endcase
			end
			OP_SAMPLE: begin
				if (item.elapsed_us != '0 && cfg.quality_mode == MODE_AUTO) begin
					sum_d = sum_inc;
					cnt_d = cnt_inc;
					if (cnt_inc >= win) begin
						priority if (sum_inc > slow_lim && cur_q < MAX_L) begin
							cur_d  = cur_q + ONE_L;
							calm_d = '0;
						end else if (sum_inc < fast_lim && cur_q > base_q) begin
							if (calm_inc >= cfg.recovery_windows) begin
								cur_d  = cur_q - ONE_L;
								calm_d = '0;
							end else begin
								calm_d = calm_inc;
							end
						end else begin
							calm_d = '0;
						end
						cnt_d = '0;
						sum_d = '0;
					end
				end
			end
			OP_CLEAR: begin
				cnt_d    = '0;
				sum_d    = '0;
				calm_d   = '0;
				held_w_d = '0;
				held_h_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_w_q <= '0;
			held_h_q <= '0;
			base_q   <= ONE_L;
			cur_q    <= ONE_L;
			cnt_q    <= '0;
			sum_q    <= '0;
			calm_q   <= '0;
		end else if (en) begin
			held_w_q <= held_w_d;
			held_h_q <= held_h_d;
			base_q   <= base_d;
			cur_q    <= cur_d;
			cnt_q    <= cnt_d;
			sum_q    <= sum_d;
			calm_q   <= calm_d;
		end else if (mode_change) begin
			held_w_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scale_q <= cur_d;
			floor_q <= base_d;
		end
	end

	assign scale       = scale_q;
	assign floor_scale = floor_q;

endmodule

// ===== rtl/core/render_scale_governor_top.sv =====
`timescale 1ns / 1ps
// Top level of the render scale governor: stream ports, APB-style registers.
// Depends on rsg_pkg, rsg_cfg, rsg_level and rsg_state.

// Every request (resolution query, render-time sample or statistics reset)
// yields exactly one result carrying the current scale and the base scale.
// The edge that accepts a request loads the input register; the request
// then passes the two base-level stages and the state and result register
// in that order, and m_tvalid rises once the result register is loaded.
// A new request is taken every cycle while the result side does not stall;
// the rate is set by the state register loop, which applies one request
// per cycle. Backpressure on the result side stalls the pipeline stage by
// stage, so requests keep entering while earlier stages are empty.
// Registers are to be written only while no request is in flight.
module render_scale_governor_top #(
	parameter int MAX_SCALE = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Fields from bit 0 up: operation, width, height, elapsed_us, zero pad.
	input  logic [rsg_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0 up: scale, floor_scale, zero pad.
	output logic [rsg_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rsg_pkg::ADDR_W-1:0]       paddr,
	input  logic [rsg_pkg::DATA_W-1:0]       pwdata,
	output logic [rsg_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);
	import rsg_pkg::*;

	localparam int F_W = 2 * DIM_W + TIME_W + OP_W;

	cfg_t              cfg;
	logic              mode_change;
	item_t             item_s1, item_s3;
	logic [LVL_W-1:0]  level_s3, scale, floor_scale;
	logic              v1_q, v2_q, v3_q, vo_q;
	logic              r1, r2, r3, ro;
	logic              acc, adv2, adv3, advo;

	assign ro   = !vo_q || m_tready;
	assign r3   = !v3_q || ro;
	assign r2   = !v2_q || r3;
	assign r1   = !v1_q || r2;
	assign acc  = s_tvalid && r1;
	assign adv2 = v1_q && r2;
	assign adv3 = v2_q && r3;
	assign advo = v3_q && ro;

	assign s_tready = r1;
	assign m_tvalid = vo_q;
	assign m_tdata  = {(OUT_TDATA_W - 2*LVL_W)'(0), floor_scale, scale};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (r1) v1_q <= s_tvalid;
			if (r2) v2_q <= v1_q;
			if (r3) v3_q <= v2_q;
			if (ro) vo_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1.op         <= op_t'(s_tdata[OP_W-1:0]);
			item_s1.width      <= s_tdata[OP_W +: DIM_W];
			item_s1.height     <= s_tdata[OP_W+DIM_W +: DIM_W];
			item_s1.elapsed_us <= s_tdata[OP_W+2*DIM_W +: TIME_W];
		end
	end

	rsg_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.cfg         (cfg),
		.mode_change (mode_change)
	);

	rsg_level #(.MAX_SCALE(MAX_SCALE)) u_level (
		.clk          (clk),
		.en_s2        (adv2),
		.en_s3        (adv3),
		.item_s1      (item_s1),
		.pixel_budget (cfg.pixel_budget),
		.item_s3      (item_s3),
		.level_s3     (level_s3)
	);

	rsg_state #(.MAX_SCALE(MAX_SCALE)) u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advo),
		.item        (item_s3),
		.level       (level_s3),
		.cfg         (cfg),
		.mode_change (mode_change),
		.scale       (scale),
		.floor_scale (floor_scale)
	);

	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (scale >= LVL_W'(1) && scale <= LVL_W'(MAX_SCALE) &&
			floor_scale >= LVL_W'(1) && floor_scale <= LVL_W'(MAX_SCALE)))
		else $error("result scale out of range");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the result side is free");

	a_state_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advo |=> m_tvalid)
		else $error("state update without a result");

	a_width_fits: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (F_W <= IN_TDATA_W))
		else $error("input fields exceed tdata");

endmodule
